### hw/rtl/glbp_pkg.sv
package glbp_pkg;

    localparam int COORD_W = 20;
    localparam int CFG_W   = 12;
    localparam int CHAR_W  = 8;
    localparam int GAP_W   = 10;
    localparam int CALC_W  = 24;
    localparam int DY_W    = 17;
    localparam int STEP_W  = 4;
    localparam int PROD_W  = CFG_W + CHAR_W;
    localparam int EST_W   = PROD_W + 8;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_LABELS = 64;
    localparam int DEF_MAX_STEPS  = 6;

    localparam logic [CFG_W-1:0] LH_RESET   = 12'd224;
    localparam logic [CFG_W-1:0] GS_RESET   = 12'd192;
    localparam logic [CFG_W-1:0] LH_MIN     = 12'd16;
    localparam logic [CFG_W-1:0] H_FALLBACK = 12'd224;
    localparam logic [CFG_W-1:0] W_BASE     = 12'd128;
    localparam logic [CFG_W-1:0] W_MAX      = 12'd2080;
    localparam logic [7:0]       WIDTH_NUM  = 8'd133;
    localparam logic [7:0]       LEADER_OFS = 8'd48;
    localparam logic [7:0]       LEADER_TOL = 8'd16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LINE_HEIGHT = 1'b0,
        REG_GLYPH_SIZE  = 1'b1
    } t_cfg_reg;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord left;
        t_coord top;
        t_coord right;
        t_coord bottom;
    } t_box;

    // candidate box travelling down the cell row
    typedef struct packed {
        logic valid;
        logic hit;
        t_box box;
    } t_probe;

    typedef struct packed {
        logic we;
        t_box box;
    } t_store_wr;

    typedef struct packed {
        logic              frame_start;
        t_coord            anchor_x;
        t_coord            anchor_y;
        logic [CHAR_W-1:0] char_count;
        logic [GAP_W-1:0]  side_gap;
    } t_item;

    typedef struct packed {
        t_coord box_left;
        t_coord box_top;
        t_coord box_right;
        t_coord box_bottom;
        logic   align_right;
        logic   leader_on;
        t_coord leader_end_x;
        t_coord leader_end_y;
        logic   placed_clean;
        logic   skipped;
    } t_result;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_WID,
        ST_BASE,
        ST_FEED,
        ST_WAIT,
        ST_FINAL,
        ST_REPORT
    } t_state;

endpackage

### hw/rtl/glbp_cell.sv
module glbp_cell import glbp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_active,
    input  logic   i_store_we,
    input  t_box   i_store_box,
    input  t_probe i_probe,
    output t_probe o_probe
);

    t_box r_box;
    logic r_valid;
    logic r_hit;
    t_box r_pbox;
    logic collide;

    // strict overlap on both axes
    assign collide = i_active && i_probe.valid &&
                     (i_probe.box.left < r_box.right) && (i_probe.box.right > r_box.left) &&
                     (i_probe.box.top < r_box.bottom) && (i_probe.box.bottom > r_box.top);

    always_ff @(posedge i_clk) begin
        if (i_store_we) begin
            r_box <= i_store_box;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_probe.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit  <= i_probe.hit | collide;
        r_pbox <= i_probe.box;
    end

    assign o_probe = '{valid: r_valid, hit: r_hit, box: r_pbox};

endmodule

### hw/rtl/glbp_chain.sv
module glbp_chain import glbp_pkg::*; #(
    parameter  int NUM_CELLS = DEF_MAX_LABELS,
    localparam int CNT_W     = $clog2(NUM_CELLS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CNT_W-1:0] i_count,
    input  t_store_wr        i_store,
    input  t_probe           i_probe,
    output t_probe           o_probe
);

    t_probe probe [NUM_CELLS+1];

    assign probe[0] = i_probe;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        logic active;
        logic we;

        // only filled entries take part; the next free entry takes the write
        assign active = CNT_W'(i) < i_count;
        assign we     = i_store.we && (i_count == CNT_W'(i));

        glbp_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_active    (active),
            .i_store_we  (we),
            .i_store_box (i_store.box),
            .i_probe     (probe[i]),
            .o_probe     (probe[i+1])
        );
    end

    assign o_probe = probe[NUM_CELLS];

endmodule

### hw/rtl/greedy_label_box_placer.sv
// greedy label box placer
// command channel: an item (t_item) transfers at a rising edge with start high and
// busy low; busy stays high until the result has been formed.
// result channel: o_result is valid for exactly one cycle while o_done is high;
// the receiver cannot stall, so a result is lost if not captured in that cycle.
// config: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 line height,
// 1 glyph size) at any edge; write only while the block is idle.
// search: each label tries NCAND candidates (NCAND = 2 + 4*MAX_STEPS); every
// candidate walks through all MAX_LABELS cells of the row, one per cycle,
// with one new candidate entering per cycle during the feed phase.
// an empty label (char_count 0) skips the search and goes straight to report.
// a new item can transfer in the cycle o_done is high; no new label is taken
// while busy is high, so each label is finished before the next one enters.
// reset: registers go to 224 and 192, the placed-box count goes to zero; the
// stored boxes themselves are not cleared, since only entries below the count
// are ever compared.
module greedy_label_box_placer import glbp_pkg::*; #(
    parameter int MAX_LABELS = DEF_MAX_LABELS,
    parameter int MAX_STEPS  = DEF_MAX_STEPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_item                i_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output logic                 o_done,
    output t_result              o_result
);

    localparam int NCAND  = 2 + 4 * MAX_STEPS;
    localparam int SEEN_W = $clog2(NCAND + 1);
    localparam int CNT_W  = $clog2(MAX_LABELS + 1);
    localparam int WRAW_W = EST_W - 7;

    // saturate to the signed coordinate range
    function automatic t_coord sat_coord(input logic signed [CALC_W-1:0] v);
        if (&v[CALC_W-1:COORD_W-1] || ~|v[CALC_W-1:COORD_W-1]) begin
            sat_coord = t_coord'(v[COORD_W-1:0]);
        end else if (v[CALC_W-1]) begin
            sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
        end
    endfunction

    function automatic logic signed [CALC_W-1:0] ext(input t_coord c);
        ext = {{(CALC_W-COORD_W){c[COORD_W-1]}}, c};
    endfunction

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_lh, r_gs;
    t_item             r_item;
    logic              r_skip;
    logic [PROD_W-1:0] r_prod;
    logic [CFG_W-1:0]  r_h, r_w;
    logic [DY_W-1:0]   r_h7;
    logic signed [CALC_W-1:0] r_rl, r_rr, r_ll, r_lr, r_top0, r_bot0;
    logic [STEP_W-1:0] r_k;
    logic [1:0]        r_sub;
    logic [DY_W-1:0]   r_hk;
    logic              r_cv;
    t_box              r_cbox;
    logic [SEEN_W-1:0] r_seen;
    logic              r_found;
    t_box              r_fbox;
    logic              r_clean;
    logic [CNT_W-1:0]  r_count;
    logic              r_done, n_done;
    t_result           r_result;

    logic accept;
    logic feed_last;
    logic k_last, sub_last;

    // ------------------------------------------------------------------
    // control
    // ------------------------------------------------------------------
    assign accept   = start && (r_state == ST_IDLE);
    assign busy     = (r_state != ST_IDLE);
    assign k_last   = (r_k == STEP_W'(MAX_STEPS));
    assign sub_last = (r_k == '0) ? (r_sub == 2'd1) : (r_sub == 2'd3);
    assign feed_last = k_last && sub_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_item.char_count == '0) ? ST_REPORT : ST_MUL;
                end
            end
            ST_MUL:  n_state = ST_WID;
            ST_WID:  n_state = ST_BASE;
            ST_BASE: n_state = ST_FEED;
            ST_FEED: begin
                if (feed_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                // all candidates have left the last cell
                if (r_seen == SEEN_W'(NCAND)) begin
                    n_state = ST_FINAL;
                end
            end
            ST_FINAL: n_state = ST_REPORT;
            ST_REPORT: begin
                n_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lh <= LH_RESET;
            r_gs <= GS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LINE_HEIGHT: r_lh <= i_cfg_data;
                REG_GLYPH_SIZE:  r_gs <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // per-label setup: height, width estimate, candidate bases
    // ------------------------------------------------------------------
    logic [EST_W-1:0]  est_full;
    logic [WRAW_W-1:0] w_raw;
    logic signed [CALC_W-1:0] ax_e, ay_e, gap_e, w_e, h_e, half_e;

    assign est_full = EST_W'(r_prod) * EST_W'(WIDTH_NUM);
    assign w_raw    = WRAW_W'(est_full[EST_W-1:8]) + WRAW_W'(W_BASE);
    assign ax_e     = ext(r_item.anchor_x);
    assign ay_e     = ext(r_item.anchor_y);
    assign gap_e    = $signed(CALC_W'(r_item.side_gap));
    assign w_e      = $signed(CALC_W'(r_w));
    assign h_e      = $signed(CALC_W'(r_h));
    assign half_e   = $signed(CALC_W'(r_h[CFG_W-1:1]));

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_item <= i_item;
                    r_skip <= (i_item.char_count == '0);
                end
            end
            ST_MUL: begin
                r_prod <= PROD_W'(r_gs) * PROD_W'(r_item.char_count);
                r_h    <= (r_lh > LH_MIN) ? r_lh : H_FALLBACK;
            end
            ST_WID: begin
                // width clipped at 2080 px
                r_w  <= (w_raw > WRAW_W'(W_MAX)) ? W_MAX : w_raw[CFG_W-1:0];
                r_h7 <= (DY_W'(r_h) << 3) - DY_W'(r_h);
            end
            ST_BASE: begin
                r_rl   <= ax_e + gap_e;
                r_rr   <= ax_e + gap_e + w_e;
                r_ll   <= ax_e - gap_e - w_e;
                r_lr   <= ax_e - gap_e;
                r_top0 <= ay_e - half_e;
                r_bot0 <= ay_e - half_e + h_e;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // candidate sequencer: right, left, then per step right up/down,
    // left up/down; in the final state the same path gives the fallback box
    // ------------------------------------------------------------------
    logic            g_right, g_neg;
    logic [DY_W-1:0] g_hk;
    logic signed [CALC_W-1:0] g_dy;
    t_box            g_box;

    always_comb begin
        if (r_state == ST_FINAL) begin
            g_right = 1'b1;
            g_neg   = 1'b0;
            g_hk    = r_h7;
        end else begin
            g_right = (r_k == '0) ? (r_sub == 2'd0) : ~r_sub[1];
            g_neg   = (r_k != '0) && ~r_sub[0];
            g_hk    = r_hk;
        end
        g_dy = $signed(CALC_W'(g_hk));
        if (g_neg) begin
            g_dy = -g_dy;
        end
        g_box.left   = sat_coord(g_right ? r_rl : r_ll);
        g_box.right  = sat_coord(g_right ? r_rr : r_lr);
        g_box.top    = sat_coord(r_top0 + g_dy);
        g_box.bottom = sat_coord(r_bot0 + g_dy);
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_BASE) begin
            r_k   <= '0;
            r_sub <= '0;
            r_hk  <= '0;
        end else if (r_state == ST_FEED) begin
            if ((r_k == '0 && r_sub == 2'd1) || r_sub == 2'd3) begin
                r_k   <= r_k + 1'b1;
                r_sub <= '0;
                r_hk  <= r_hk + DY_W'(r_h);
            end else begin
                r_sub <= r_sub + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else begin
            r_cv <= (r_state == ST_FEED);
        end
    end

    always_ff @(posedge i_clk) begin
        r_cbox <= g_box;
    end

    // ------------------------------------------------------------------
    // cell row holding the placed boxes
    // ------------------------------------------------------------------
    t_probe    chain_in, chain_out;
    t_store_wr store;

    assign chain_in  = '{valid: r_cv, hit: 1'b0, box: r_cbox};
    assign store.we  = (r_state == ST_FINAL) && (r_count < CNT_W'(MAX_LABELS));
    assign store.box = r_found ? r_fbox : g_box;

    glbp_chain #(
        .NUM_CELLS (MAX_LABELS)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_count (r_count),
        .i_store (store),
        .i_probe (chain_in),
        .o_probe (chain_out)
    );

    // candidates leave in issue order: the first one without a hit wins
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen  <= '0;
            r_found <= 1'b0;
        end else if (r_state == ST_BASE) begin
            r_seen  <= '0;
            r_found <= 1'b0;
        end else if (chain_out.valid) begin
            r_seen <= r_seen + 1'b1;
            if (!chain_out.hit && !r_found) begin
                r_found <= 1'b1;
                r_fbox  <= chain_out.box;
            end
        end else if (r_state == ST_FINAL) begin
            r_clean <= r_found;
            if (!r_found) begin
                r_fbox <= g_box;
            end
        end
    end

    // fill count, saturating once the row is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (accept && i_item.frame_start) begin
            r_count <= '0;
        end else if (store.we) begin
            r_count <= r_count + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // result: alignment, leader line
    // ------------------------------------------------------------------
    logic align;
    logic signed [CALC_W-1:0] ex_raw, sum, ey_e, diff;
    t_coord ey;
    logic leader;

    assign align  = r_fbox.left < r_item.anchor_x;
    assign ex_raw = align ? ext(r_fbox.right) + $signed(CALC_W'(LEADER_OFS))
                          : ext(r_fbox.left) - $signed(CALC_W'(LEADER_OFS));
    assign sum    = ext(r_fbox.top) + ext(r_fbox.bottom);
    assign ey     = t_coord'(sum[COORD_W:1]);
    assign ey_e   = ext(ey);
    assign diff   = ey_e - ay_e;
    assign leader = align || (diff > $signed(CALC_W'(LEADER_TOL))) ||
                    (diff < -$signed(CALC_W'(LEADER_TOL)));

    always_ff @(posedge i_clk) begin
        if (r_state == ST_REPORT) begin
            if (r_skip) begin
                r_result <= '{skipped: 1'b1, default: '0};
            end else begin
                r_result.box_left     <= r_fbox.left;
                r_result.box_top      <= r_fbox.top;
                r_result.box_right    <= r_fbox.right;
                r_result.box_bottom   <= r_fbox.bottom;
                r_result.align_right  <= align;
                r_result.leader_on    <= leader;
                r_result.leader_end_x <= sat_coord(ex_raw);
                r_result.leader_end_y <= ey;
                r_result.placed_clean <= r_clean;
                r_result.skipped      <= 1'b0;
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_LABELS))
        else $error("fill count beyond row length");

    a_done_after_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state) == ST_REPORT)
        else $error("result strobe without report state");

    a_seen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seen <= SEEN_W'(NCAND))
        else $error("more candidates left the row than were issued");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> busy)
        else $error("not busy after a command transfer");

    a_probe_from_feed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cv |-> $past(r_state) == ST_FEED)
        else $error("candidate entered the row outside the feed phase");

endmodule

### tb/sv/label_placement_checker.sv
module label_placement_checker import glbp_pkg::*; #(
    parameter int MAX_LABELS = DEF_MAX_LABELS,
    parameter int MAX_STEPS  = DEF_MAX_STEPS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_item                i_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_done,
    input  t_result              i_result,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked,
    output int                   o_crowded
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint COORD_HI       = 524287;
    localparam longint COORD_LO       = -524288;
    localparam int     FALLBACK_LINES = 7;

    typedef struct {
        longint l;
        longint t;
        longint r;
        longint b;
    } t_rect;

    t_rect            placed [MAX_LABELS];
    int               placed_n = 0;
    logic [CFG_W-1:0] line_height_q = LH_RESET;
    logic [CFG_W-1:0] glyph_size_q  = GS_RESET;
    t_result          expected_q [$];
    int               fails   = 0;
    int               checked = 0;
    int               crowded = 0;

    function automatic longint clamp_coord(longint v);
        if (v > COORD_HI) return COORD_HI;
        if (v < COORD_LO) return COORD_LO;
        return v;
    endfunction

    function automatic t_rect rect_at(bit on_right, longint dy, longint ax, longint ay,
                                      longint gap, longint w, longint h);
        t_rect  c;
        longint left;
        longint top;
        left = on_right ? ax + gap : ax - gap - w;
        top  = ay - (h >>> 1) + dy;
        c.l  = clamp_coord(left);
        c.r  = clamp_coord(left + w);
        c.t  = clamp_coord(top);
        c.b  = clamp_coord(top + h);
        return c;
    endfunction

    // strict overlap on both axes against every stored box
    function automatic bit hits_placed(t_rect c);
        int i;
        for (i = 0; i < placed_n; i++) begin
            if (c.l < placed[i].r && c.r > placed[i].l && c.t < placed[i].b && c.b > placed[i].t)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // picks the first free candidate, updates the store, forms the result
    function automatic t_result place_label(t_item it);
        t_result res;
        t_rect   rect;
        t_rect   cand;
        longint  ax, ay, gap, h, w, ex, ey, dy;
        bit      clean;
        bit      align;
        int      k, s;
        res = '0;
        if (it.frame_start) placed_n = 0;
        if (it.char_count == 0) begin
            res.skipped = 1'b1;
            return res;
        end
        ax  = longint'($signed(it.anchor_x));
        ay  = longint'($signed(it.anchor_y));
        gap = longint'(it.side_gap);
        h   = (line_height_q > LH_MIN) ? longint'(line_height_q) : longint'(H_FALLBACK);
        w   = longint'(W_BASE)
              + ((longint'(WIDTH_NUM) * longint'(glyph_size_q) * longint'(it.char_count)) >>> 8);
        if (w > longint'(W_MAX)) w = longint'(W_MAX);

        rect  = rect_at(1'b1, 0, ax, ay, gap, w, h);
        clean = !hits_placed(rect);
        if (!clean) begin
            cand = rect_at(1'b0, 0, ax, ay, gap, w, h);
            if (!hits_placed(cand)) begin
                rect  = cand;
                clean = 1'b1;
            end
            for (k = 1; k <= MAX_STEPS && !clean; k++) begin
                for (s = 0; s < 4 && !clean; s++) begin
                    dy   = (s % 2 == 1) ? h * k : -(h * k);
                    cand = rect_at(s < 2, dy, ax, ay, gap, w, h);
                    if (!hits_placed(cand)) begin
                        rect  = cand;
                        clean = 1'b1;
                    end
                end
            end
        end
        if (!clean) rect = rect_at(1'b1, h * FALLBACK_LINES, ax, ay, gap, w, h);

        // store saturates at capacity, later boxes are still reported
        if (placed_n < MAX_LABELS) begin
            placed[placed_n] = rect;
            placed_n++;
        end

        align = rect.l < ax;
        ex    = clamp_coord(align ? rect.r + longint'(LEADER_OFS) : rect.l - longint'(LEADER_OFS));
        ey    = (rect.t + rect.b) >>> 1;

        res.box_left     = t_coord'(rect.l);
        res.box_top      = t_coord'(rect.t);
        res.box_right    = t_coord'(rect.r);
        res.box_bottom   = t_coord'(rect.b);
        res.align_right  = align;
        res.leader_on    = (ey - ay > longint'(LEADER_TOL)) || (ay - ey > longint'(LEADER_TOL))
                           || align;
        res.leader_end_x = t_coord'(ex);
        res.leader_end_y = t_coord'(ey);
        res.placed_clean = clean;
        res.skipped      = 1'b0;
        return res;
    endfunction

    task automatic check_field(string name, logic [COORD_W-1:0] want, logic [COORD_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            line_height_q = LH_RESET;
            glyph_size_q  = GS_RESET;
            placed_n      = 0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    REG_LINE_HEIGHT: line_height_q = i_cfg_data;
                    REG_GLYPH_SIZE:  glyph_size_q  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_done) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with no label outstanding");
                    fails++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("box_left",     want.box_left,     i_result.box_left);
                    check_field("box_top",      want.box_top,      i_result.box_top);
                    check_field("box_right",    want.box_right,    i_result.box_right);
                    check_field("box_bottom",   want.box_bottom,   i_result.box_bottom);
                    check_field("align_right",  COORD_W'(want.align_right),
                                COORD_W'(i_result.align_right));
                    check_field("leader_on",    COORD_W'(want.leader_on),
                                COORD_W'(i_result.leader_on));
                    check_field("leader_end_x", want.leader_end_x, i_result.leader_end_x);
                    check_field("leader_end_y", want.leader_end_y, i_result.leader_end_y);
                    check_field("placed_clean", COORD_W'(want.placed_clean),
                                COORD_W'(i_result.placed_clean));
                    check_field("skipped",      COORD_W'(want.skipped),
                                COORD_W'(i_result.skipped));
                    checked++;
                end
            end
            if (i_start && !i_busy) begin
                want = place_label(i_item);
                if (!want.skipped && !want.placed_clean) crowded++;
                expected_q = {expected_q, want};
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_q.size();
        o_checked    <= checked;
        o_crowded    <= crowded;
    end

endmodule

### tb/sv/testbench.sv
module testbench;
    import glbp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_HI = 524287;
    localparam int COORD_LO = -524288;
    localparam int N_RANDOM = 927;

    logic                 i_clk      = 1'b0;
    logic                 i_rst_n    = 1'b0;
    logic                 start      = 1'b0;
    logic                 busy;
    t_item                i_item     = '0;
    logic                 i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx  = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_done;
    t_result              o_result;

    int fail_count;
    int pending;
    int checked;
    int crowded;

    // stimulus bookkeeping, only for the closing summary and cluster sizing
    int               labels_sent = 0;
    int               settings    = 0;
    int               frames      = 0;
    logic [CFG_W-1:0] cur_lh      = LH_RESET;

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    greedy_label_box_placer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    label_placement_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_done       (o_done),
        .i_result     (o_result),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_crowded    (crowded)
    );

    function automatic t_item label_item(bit fs, int x, int y, int chars, int gap);
        t_item it;
        it.frame_start = fs;
        it.anchor_x    = t_coord'(x);
        it.anchor_y    = t_coord'(y);
        it.char_count  = chars[CHAR_W-1:0];
        it.side_gap    = gap[GAP_W-1:0];
        return it;
    endfunction

    function automatic int fit_coord(int v);
        if (v > COORD_HI) return COORD_HI;
        if (v < COORD_LO) return COORD_LO;
        return v;
    endfunction

    // one command transfer; start is only lowered when an idle gap follows,
    // so back-to-back labels keep it high across the edge
    task automatic send_label(t_item it, int idle);
        if (idle > 0) begin
            start <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        labels_sent++;
    endtask

    // registers change only once every label has reported and the block is idle
    task automatic write_regs(logic [CFG_W-1:0] lh, logic [CFG_W-1:0] gs);
        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0 || busy);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_LINE_HEIGHT;
        i_cfg_data <= lh;
        @(posedge i_clk);
        i_cfg_idx  <= REG_GLYPH_SIZE;
        i_cfg_data <= gs;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_lh = lh;
        settings++;
    endtask

    function automatic logic [CFG_W-1:0] pick_line_height();
        case ($urandom_range(0, 7))
            0:       return 12'd0;
            1:       return LH_MIN;
            2:       return LH_MIN + 12'd1;
            3:       return 12'd4095;
            4:       return LH_RESET;
            5:       return CFG_W'($urandom_range(0, 4095));
            default: return CFG_W'($urandom_range(17, 600));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_glyph_size();
        case ($urandom_range(0, 6))
            0:       return 12'd0;
            1:       return 12'd1;
            2:       return 12'd4095;
            3:       return GS_RESET;
            4:       return CFG_W'($urandom_range(0, 4095));
            default: return CFG_W'($urandom_range(100, 400));
        endcase
    endfunction

    // labels come mostly in frames clustered around one point so that the
    // candidate search runs deep and the store fills; the rest is noise
    task automatic random_phase(int n_items, bit no_idle);
        int    frame_left;
        int    ctr_x, ctr_y, spread, h_eff, edge_x, edge_y;
        int    x, y, chars, gap, idle, i;
        bit    new_frame;
        t_item it;
        frame_left = 0;
        ctr_x      = 0;
        ctr_y      = 0;
        spread     = 0;
        h_eff      = (cur_lh > LH_MIN) ? int'(cur_lh) : int'(H_FALLBACK);
        for (i = 0; i < n_items; i++) begin
            idle = no_idle ? 0 : $urandom_range(0, 13);
            if ($urandom_range(0, 99) < 15) begin
                // noise: every field drawn over its full range
                it.frame_start = 1'($urandom_range(0, 1));
                it.anchor_x    = t_coord'($urandom());
                it.anchor_y    = t_coord'($urandom());
                it.char_count  = CHAR_W'($urandom_range(0, 255));
                it.side_gap    = GAP_W'($urandom_range(0, 1023));
            end else begin
                new_frame = (frame_left == 0);
                if (frame_left == 0) begin
                    case ($urandom_range(0, 9))
                        0:       frame_left = $urandom_range(1, 4);
                        1, 2:    frame_left = $urandom_range(60, 80);
                        default: frame_left = $urandom_range(5, 30);
                    endcase
                    if ($urandom_range(0, 9) < 7) begin
                        ctr_x = int'($urandom_range(0, 200000)) - 100000;
                        ctr_y = int'($urandom_range(0, 200000)) - 100000;
                    end else begin
                        // near the coordinate limits, exercises saturation
                        edge_x = COORD_HI - int'($urandom_range(0, 3000));
                        edge_y = COORD_HI - int'($urandom_range(0, 3000));
                        ctr_x  = $urandom_range(0, 1) ? edge_x : -edge_x;
                        ctr_y  = $urandom_range(0, 1) ? edge_y : -edge_y;
                    end
                    case ($urandom_range(0, 2))
                        0:       spread = 32;
                        1:       spread = h_eff;
                        default: spread = 4 * h_eff;
                    endcase
                    frames++;
                end
                x = fit_coord(ctr_x + int'($urandom_range(0, 2 * spread)) - spread);
                y = fit_coord(ctr_y + int'($urandom_range(0, 2 * spread)) - spread);
                case ($urandom_range(0, 19))
                    0:              chars = 0;
                    1, 2, 3, 4, 5:  chars = $urandom_range(21, 255);
                    default:        chars = $urandom_range(1, 20);
                endcase
                gap = ($urandom_range(0, 9) < 6) ? $urandom_range(0, 64) : $urandom_range(0, 1023);
                it = label_item(new_frame, x, y, chars, gap);
                frame_left--;
            end
            send_label(it, idle);
        end
    endtask

    initial begin
        int random_sent;
        int n;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset values: the candidate order around one anchor
        send_label(label_item(1'b1, 0, 0, 5, 32), $urandom_range(0, 13));
        send_label(label_item(1'b0, 0, 0, 5, 32), $urandom_range(0, 13));
        send_label(label_item(1'b0, 0, 0, 5, 32), $urandom_range(0, 13));
        send_label(label_item(1'b0, 0, 0, 5, 32), $urandom_range(0, 13));
        send_label(label_item(1'b0, 0, 0, 5, 32), $urandom_range(0, 13));
        // empty labels, with and without a frame clear
        send_label(label_item(1'b0, 0, 0, 0, 32), $urandom_range(0, 13));
        send_label(label_item(1'b1, 0, 0, 0, 32), $urandom_range(0, 13));
        send_label(label_item(1'b0, 0, 0, 5, 32), $urandom_range(0, 13));
        // coordinate corners, widest gap and longest label
        send_label(label_item(1'b0, COORD_HI, COORD_HI, 255, 1023), $urandom_range(0, 13));
        send_label(label_item(1'b0, COORD_LO, COORD_LO, 255, 1023), $urandom_range(0, 13));
        send_label(label_item(1'b0, COORD_LO, COORD_HI, 1, 0), $urandom_range(0, 13));
        send_label(label_item(1'b0, COORD_HI, COORD_LO, 1, 0), $urandom_range(0, 13));

        // height at the fallback threshold, width at its cap
        write_regs(LH_MIN, 12'd4095);
        send_label(label_item(1'b1, 1000, -1000, 255, 0), $urandom_range(0, 13));
        send_label(label_item(1'b0, 1000, -1000, 200, 0), $urandom_range(0, 13));
        send_label(label_item(1'b0, 1000, -1000, 255, 1023), $urandom_range(0, 13));

        // tallest line, narrowest box; bottom edge runs into saturation
        write_regs(12'd4095, 12'd0);
        send_label(label_item(1'b1, 0, 0, 1, 0), $urandom_range(0, 13));
        send_label(label_item(1'b0, 0, COORD_HI - 10, 100, 0), $urandom_range(0, 13));
        send_label(label_item(1'b0, 0, COORD_HI - 10, 100, 0), $urandom_range(0, 13));
        send_label(label_item(1'b0, 0, COORD_HI - 10, 100, 0), $urandom_range(0, 13));

        // just above the threshold, and height zero
        write_regs(LH_MIN + 12'd1, 12'd1);
        send_label(label_item(1'b1, -5000, 5000, 8, 16), $urandom_range(0, 13));
        send_label(label_item(1'b0, -5000, 5000, 8, 16), $urandom_range(0, 13));
        write_regs(12'd0, GS_RESET);
        send_label(label_item(1'b1, 300, 300, 12, 64), $urandom_range(0, 13));
        send_label(label_item(1'b0, 300, 300, 12, 64), $urandom_range(0, 13));

        // random part: one register setting per phase, some phases without idling
        random_sent = 0;
        while (random_sent < N_RANDOM) begin
            write_regs(pick_line_height(), pick_glyph_size());
            n = $urandom_range(40, 120);
            if (n > N_RANDOM - random_sent) n = N_RANDOM - random_sent;
            random_phase(n, $urandom_range(0, 3) == 0);
            random_sent += n;
        end

        start <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        // room for any stray result after the last one expected
        repeat (120) @(posedge i_clk);

        $display("%0d labels sent over %0d register settings and %0d clustered frames",
                 labels_sent, settings, frames);
        $display("%0d results compared, %0d of them pushed to the crowded fallback spot",
                 checked, crowded);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // watchdog, several times the slowest legal run
    initial begin
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
